FILE: rtl/qte_pkg.sv
package qte_pkg;

  // configuration of the datapath
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;

  // fixed point layout: products in Q4.28, forms in Q6.28, 1.0 = 2^28
  localparam int Q_FRAC = 28;
  localparam int IN_W   = 34;
  localparam int CW     = IN_W + 3;
  localparam int ZW     = ANGLE_BITS + 2;
  localparam int S_W    = Q_FRAC + 2;
  localparam int ROOT_W = Q_FRAC + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int TAB_LEN = 24;

  localparam logic signed [IN_W-1:0] ONE_Q = IN_W'(1 << Q_FRAC);
  localparam logic [RAD_W-1:0]       RAD_ONE = RAD_W'(1) << (2 * Q_FRAC);

  localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(1 << (ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] HALF_Z    = ZW'(1 << (ANGLE_BITS - 1));
  localparam logic signed [15:0]   QUARTER_16 = 16'sd16384;

  // scaling of the angle datapath to the 16 bit result
  localparam int OUT_SHR = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int OUT_SHL = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int OUT_RND = (1 << OUT_SHR) >> 1;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } euler_t;

  // operands carried alongside the square root
  typedef struct packed {
    logic signed [IN_W-1:0] roll_y;
    logic signed [IN_W-1:0] roll_x;
    logic signed [IN_W-1:0] yaw_y;
    logic signed [IN_W-1:0] yaw_x;
    logic signed [S_W-1:0]  sin_p;
    logic                   clamped;
  } side_t;

  // rounded micro-rotation angle of one cordic stage
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    return ZW'((ATAN_TAB[i] + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));
  endfunction

  // angle datapath to 16 bit binary angle, wraps
  function automatic logic [15:0] to_out16(input logic signed [ZW-1:0] z);
    logic signed [ZW+15:0] w;
    w = (ZW+16)'(z);
    w = (w + (ZW+16)'(OUT_RND)) >>> OUT_SHR;
    w = w <<< OUT_SHL;
    return w[15:0];
  endfunction

endpackage

FILE: rtl/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t            side_o
);

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  side_t             side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  // one result bit per stage, two radicand bits brought down each step
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    side_t             side_p;
    logic              vld_p;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign rem_in = {rem_p[REM_W-3:0], rad_p[RAD_W-1:RAD_W-2]};
    assign trial  = REM_W'({root_p, 2'b01});
    assign ge     = (rem_in >= trial);

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    // digit step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_in - trial) : rem_in;
        root_q[k] <= {root_p[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_p[RAD_W-3:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

FILE: rtl/qte_cordic.sv
module qte_cordic import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] y_i,
  input  logic signed [IN_W-1:0] x_i,
  input  logic                   tag_i,
  output logic                   valid_o,
  output logic signed [ZW-1:0]   angle_o,
  output logic                   tag_o
);

  logic signed [CW-1:0] x_ext, y_ext;
  logic signed [CW-1:0] pre_x, pre_y;
  logic signed [ZW-1:0] pre_z;
  logic                 pre_h;

  logic signed [CW-1:0] xs_q   [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys_q   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] zs_q   [CORDIC_STAGES+1];
  logic                 hold_q [CORDIC_STAGES+1];
  logic                 tag_q  [CORDIC_STAGES+1];
  logic                 vld_q  [CORDIC_STAGES+1];

  assign x_ext = CW'(x_i);
  assign y_ext = CW'(y_i);

  // axis cases and pre-rotation of the left half plane
  always_comb begin
    pre_x = x_ext;
    pre_y = y_ext;
    pre_z = '0;
    pre_h = 1'b0;
    if (x_ext == 0) begin
      pre_h = 1'b1;
      if (y_ext > 0) begin
        pre_z = QUARTER_Z;
      end else if (y_ext < 0) begin
        pre_z = -QUARTER_Z;
      end
    end else if (y_ext == 0) begin
      pre_h = 1'b1;
      if (x_ext < 0) begin
        pre_z = HALF_Z;
      end
    end else if (x_ext < 0) begin
      if (y_ext >= 0) begin
        pre_x = y_ext;
        pre_y = -x_ext;
        pre_z = QUARTER_Z;
      end else begin
        pre_x = -y_ext;
        pre_y = x_ext;
        pre_z = -QUARTER_Z;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]   <= pre_x;
      ys_q[0]   <= pre_y;
      zs_q[0]   <= pre_z;
      hold_q[0] <= pre_h;
      tag_q[0]  <= tag_i;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] step;

    assign dx   = ys_q[k-1] >>> (k - 1);
    assign dy   = xs_q[k-1] >>> (k - 1);
    assign step = atan_step(k - 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hold_q[k] <= hold_q[k-1];
        tag_q[k]  <= tag_q[k-1];
        if (ys_q[k-1] > 0) begin
          xs_q[k] <= xs_q[k-1] + dx;
          ys_q[k] <= ys_q[k-1] - dy;
          zs_q[k] <= hold_q[k-1] ? zs_q[k-1] : zs_q[k-1] + step;
        end else begin
          xs_q[k] <= xs_q[k-1] - dx;
          ys_q[k] <= ys_q[k-1] + dy;
          zs_q[k] <= hold_q[k-1] ? zs_q[k-1] : zs_q[k-1] - step;
        end
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES];
  assign angle_o = zs_q[CORDIC_STAGES];
  assign tag_o   = tag_q[CORDIC_STAGES];

endmodule

FILE: rtl/quaternion_to_euler_angles.sv
// Quaternion (scalar first, Q2.14) to ZYX roll, pitch and yaw as 16 bit binary angles
// (32768 = pi). Fully pipelined: one transfer in and one out per cycle while the output is
// taken, through three arithmetic stages, the 29 stage bit-serial square root, the unrolled
// atan2 CORDIC stages and the result register. A stall on the output holds the whole
// pipeline, bubbles included, until the result register is taken. Pitch argument beyond
// unit magnitude is clamped and flagged.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  quat_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output euler_t out_data_o
);

  logic adv;

  logic signed [31:0] p_yz_q, p_wx_q, p_xx_q, p_yy_q, p_xy_q;
  logic signed [31:0] p_wz_q, p_zz_q, p_xz_q, p_wy_q;
  logic               v1_q;

  side_t              side2_d, side2_q;
  logic signed [IN_W-1:0] s_full;
  logic               v2_q;

  logic [ROOT_W-1:0]  s_mag;
  logic [RAD_W-1:0]   sq_d, sq_q;
  side_t              side3_q;
  logic               v3_q;

  logic               v4;
  logic [ROOT_W-1:0]  root;
  side_t              side4;

  logic               roll_vld, pit_vld, yaw_vld;
  logic               roll_tag, pit_tag, yaw_tag;
  logic signed [ZW-1:0] roll_z, pit_z, yaw_z;
  logic signed [ZW-1:0] pit_neg, pit_sat;

  euler_t             out_d, out_q;
  logic               out_valid_q;

  // whole pipeline moves when the result register is free or being taken
  assign adv        = out_ready_i || !out_valid_q;
  assign in_ready_o = adv;

  // stage 1: component products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      p_wx_q <= in_data_i.quat_w * in_data_i.quat_x;
      p_xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      p_yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      p_xy_q <= in_data_i.quat_x * in_data_i.quat_y;
      p_wz_q <= in_data_i.quat_w * in_data_i.quat_z;
      p_zz_q <= in_data_i.quat_z * in_data_i.quat_z;
      p_xz_q <= in_data_i.quat_x * in_data_i.quat_z;
      p_wy_q <= in_data_i.quat_w * in_data_i.quat_y;
    end
  end

  // stage 2: quadratic forms and clamp of the arcsine argument
  always_comb begin
    side2_d.roll_y = (IN_W'(p_yz_q) + IN_W'(p_wx_q)) <<< 1;
    side2_d.roll_x = ONE_Q - ((IN_W'(p_xx_q) + IN_W'(p_yy_q)) <<< 1);
    side2_d.yaw_y  = (IN_W'(p_xy_q) + IN_W'(p_wz_q)) <<< 1;
    side2_d.yaw_x  = ONE_Q - ((IN_W'(p_yy_q) + IN_W'(p_zz_q)) <<< 1);
    s_full         = (IN_W'(p_xz_q) - IN_W'(p_wy_q)) <<< 1;
    side2_d.clamped = 1'b0;
    side2_d.sin_p   = S_W'(s_full);
    if (s_full > ONE_Q) begin
      side2_d.sin_p   = S_W'(ONE_Q);
      side2_d.clamped = 1'b1;
    end else if (s_full < -ONE_Q) begin
      side2_d.sin_p   = S_W'(-ONE_Q);
      side2_d.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side2_d;
    end
  end

  // stage 3: square of the clamped argument
  assign s_mag = (side2_q.sin_p < 0) ? ROOT_W'(-side2_q.sin_p) : ROOT_W'(side2_q.sin_p);
  assign sq_d  = s_mag * s_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q    <= sq_d;
      side3_q <= side2_q;
    end
  end

  // cosine of pitch as floor(sqrt(1 - s^2))
  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (RAD_ONE - sq_q),
    .side_i  (side3_q),
    .valid_o (v4),
    .root_o  (root),
    .side_o  (side4)
  );

  // three atan2 units in lockstep
  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4),
    .y_i     (side4.roll_y),
    .x_i     (side4.roll_x),
    .tag_i   (side4.clamped),
    .valid_o (roll_vld),
    .angle_o (roll_z),
    .tag_o   (roll_tag)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4),
    .y_i     (IN_W'(side4.sin_p)),
    .x_i     (signed'(IN_W'(root))),
    .tag_i   (side4.clamped),
    .valid_o (pit_vld),
    .angle_o (pit_z),
    .tag_o   (pit_tag)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4),
    .y_i     (side4.yaw_y),
    .x_i     (side4.yaw_x),
    .tag_i   (side4.clamped),
    .valid_o (yaw_vld),
    .angle_o (yaw_z),
    .tag_o   (yaw_tag)
  );

  // pitch negation and saturation to a quarter turn
  always_comb begin
    pit_neg = -pit_z;
    pit_sat = pit_neg;
    if (pit_neg > QUARTER_Z) begin
      pit_sat = QUARTER_Z;
    end else if (pit_neg < -QUARTER_Z) begin
      pit_sat = -QUARTER_Z;
    end
    out_d.roll_angle    = to_out16(roll_z);
    out_d.pitch_angle   = to_out16(pit_sat);
    out_d.yaw_angle     = to_out16(yaw_z);
    out_d.pitch_clamped = pit_tag;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pit_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_lockstep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (roll_vld == pit_vld) && (yaw_vld == pit_vld))
    else $error("atan2 units out of step");

  a_lockstep_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pit_vld |-> (roll_tag == pit_tag) && (yaw_tag == pit_tag))
    else $error("clamp flag misaligned between atan2 units");

  a_clamp_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pitch_clamped) |->
      (out_data_o.pitch_angle == QUARTER_16) || (out_data_o.pitch_angle == -QUARTER_16))
    else $error("clamped pitch is not a quarter turn");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.pitch_angle <= QUARTER_16) && (out_data_o.pitch_angle >= -QUARTER_16))
    else $error("pitch beyond a quarter turn");
`endif

endmodule

FILE: dv/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  quat_t  in_data;
  logic   out_valid;
  logic   out_ready;
  euler_t out_data;

  euler_t expected_angles[$];
  int     fail_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     recv_hold;

  quaternion_to_euler_angles dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // timeout
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // shift right that floors negative values
  function automatic longint floor_shr(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-1 - v) >>> s) - 1;
  endfunction

  function automatic longint stage_angle(input int i);
    longint unsigned t;
    int sh;
    sh = 32 - ANGLE_BITS;
    t = longint'(ATAN_TAB[i]);
    return longint'((t + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // vectoring atan2 in the angle datapath units
  function automatic longint vector_atan2(input longint ya, input longint xa);
    longint quarter, ang, t, dx, dy, xv, yv;
    quarter = longint'(1) << (ANGLE_BITS - 2);
    ang = 0;
    xv = xa;
    yv = ya;
    if (xv == 0) return yv > 0 ? quarter : (yv < 0 ? -quarter : 0);
    if (yv == 0) return xv > 0 ? 0 : 2 * quarter;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = quarter;
      end else begin
        xv = -yv; yv = t; ang = -quarter;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; ang += stage_angle(i);
      end else begin
        xv -= dx; yv += dy; ang -= stage_angle(i);
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] angle_to_16(input longint a);
    int sh;
    sh = ANGLE_BITS - 16;
    if (sh > 0) a = floor_shr(a + (longint'(1) << (sh - 1)), sh);
    else if (sh < 0) a = a * (longint'(1) << (-sh));
    return a[15:0];
  endfunction

  // expected roll, pitch and yaw of one quaternion
  function automatic euler_t euler_of(input quat_t q);
    longint w, x, y, z, one, quarter, ry, rx, yy, yx, s, c, p;
    euler_t e;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    one = longint'(1) << 28;
    quarter = longint'(1) << (ANGLE_BITS - 2);
    ry = 2 * (y * z + w * x);
    rx = one - 2 * (x * x + y * y);
    yy = 2 * (x * y + w * z);
    yx = one - 2 * (y * y + z * z);
    s = 2 * (x * z - w * y);
    e.pitch_clamped = 1'b0;
    if (s > one) begin
      s = one; e.pitch_clamped = 1'b1;
    end else if (s < -one) begin
      s = -one; e.pitch_clamped = 1'b1;
    end
    c = longint'(floor_sqrt((64'd1 << 56) - longint'(s * s)));
    p = -vector_atan2(s, c);
    if (p > quarter) p = quarter;
    if (p < -quarter) p = -quarter;
    e.roll_angle  = angle_to_16(vector_atan2(ry, rx));
    e.pitch_angle = angle_to_16(p);
    e.yaw_angle   = angle_to_16(vector_atan2(yy, yx));
    return e;
  endfunction

  // send one quaternion, with random idle cycles before it
  task automatic send_quat(input quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_angles.push_back(euler_of(q));
  endtask

  // receiver ready, random stalls or a forced hold-off
  always @(posedge clk) begin
    if (rst_n) out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        e = expected_angles.pop_front();
        if (out_data.roll_angle !== e.roll_angle) begin
          $error("roll_angle exp %0d got %0d", e.roll_angle, out_data.roll_angle);
          fail_count++;
        end
        if (out_data.pitch_angle !== e.pitch_angle) begin
          $error("pitch_angle exp %0d got %0d", e.pitch_angle, out_data.pitch_angle);
          fail_count++;
        end
        if (out_data.yaw_angle !== e.yaw_angle) begin
          $error("yaw_angle exp %0d got %0d", e.yaw_angle, out_data.yaw_angle);
          fail_count++;
        end
        if (out_data.pitch_clamped !== e.pitch_clamped) begin
          $error("pitch_clamped exp %0b got %0b", e.pitch_clamped, out_data.pitch_clamped);
          fail_count++;
        end
      end
    end
  end

  function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  // random component, mostly in range, sometimes any 16 bit value
  function automatic int rand_comp();
    if ($urandom_range(9) == 0) return int'($signed(16'($urandom)));
    return $urandom_range(32768) - 16384;
  endfunction

  // roughly unit quaternion from random direction
  function automatic quat_t rand_unit_quat();
    real w, x, y, z, n;
    w = real'(rand_comp()); x = real'(rand_comp());
    y = real'(rand_comp()); z = real'(rand_comp());
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) return make_quat(16384, 0, 0, 0);
    return make_quat(int'(w * 16384.0 / n), int'(x * 16384.0 / n),
                     int'(y * 16384.0 / n), int'(z * 16384.0 / n));
  endfunction

  task automatic test_directed();
    int v[] = '{-16384, 16384, 0, 11585, -11585};
    send_quat(make_quat(16384, 0, 0, 0));
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(-16384, 0, 0, 0));
    send_quat(make_quat(0, 16384, 0, 0));
    send_quat(make_quat(0, 0, 16384, 0));
    send_quat(make_quat(0, 0, 0, 16384));
    send_quat(make_quat(0, 0, 0, -16384));
    // gimbal lock, both signs
    send_quat(make_quat(11585, 0, 11585, 0));
    send_quat(make_quat(11585, 0, -11585, 0));
    // pitch argument clamped, both signs
    send_quat(make_quat(16384, 0, 16384, 0));
    send_quat(make_quat(16384, 0, -16384, 0));
    send_quat(make_quat(-32768, 32767, 32767, -32768));
    send_quat(make_quat(32767, -32768, -32768, 32767));
    send_quat(make_quat(-1, -1, -1, -1));
    for (int i = 0; i < 10; i++)
      send_quat(make_quat(v[$urandom_range(4)], v[$urandom_range(4)],
                          v[$urandom_range(4)], v[$urandom_range(4)]));
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++)
      send_quat($urandom_range(3) == 0 ?
                make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()) :
                rand_unit_quat());
  endtask

  // receiver held off so the pipeline fills and stalls the input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_quat(rand_unit_quat());
    join
  endtask

  initial begin
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(220, 0, 0);
    test_random(180, 75, 0);
    test_random(180, 0, 75);
    test_random(180, 38, 38);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
